### rtl/core/three_axis_window_average_check_top_assert.svh
// Assertion macros for the three-axis window average check.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef THREE_AXIS_WINDOW_AVERAGE_CHECK_TOP_ASSERT_SVH
`define THREE_AXIS_WINDOW_AVERAGE_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/twac_pkg.sv
// Shared types and constants for the three-axis window average check.
// No dependencies; compile first.
package twac_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WINDOW_DEF = 20;

	localparam int NUM_AXES = 3;
	localparam int AXIS_X   = 0;
	localparam int AXIS_Y   = 1;
	localparam int AXIS_Z   = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_X_LOW  = 3'd0;
	localparam cfg_idx_t REG_X_HIGH = 3'd1;
	localparam cfg_idx_t REG_Y_LOW  = 3'd2;
	localparam cfg_idx_t REG_Y_HIGH = 3'd3;
	localparam cfg_idx_t REG_Z_LOW  = 3'd4;
	localparam cfg_idx_t REG_Z_HIGH = 3'd5;

	// Limit reset values, signed Q8.8
	localparam int X_LOW_RST  = -3840;
	localparam int X_HIGH_RST = 3840;
	localparam int Y_LOW_RST  = -1280;
	localparam int Y_HIGH_RST = 1280;
	localparam int Z_LOW_RST  = -512;
	localparam int Z_HIGH_RST = 512;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [1:0] status_t;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_X_OUT = 2'd1;
	localparam status_t STAT_Y_OUT = 2'd2;
	localparam status_t STAT_Z_OUT = 2'd3;

	// Ring control: load captures a new sample and its old slot value,
	// commit retires the stage-1 sample into the ring and the running sum.
	typedef struct packed {
		logic load;
		logic commit;
	} ring_ctl_t;

endpackage

### rtl/core/twac_ifs.sv
// Channel interfaces: sample input and status output, valid/ready.
// Depends on twac_pkg.
interface twac_sample_if;
	import twac_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_x;
	sample_t sample_y;
	sample_t sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface twac_status_if;
	import twac_pkg::*;

	logic    valid;
	logic    ready;
	status_t axis_status;

	modport source (output valid, output axis_status, input ready);
	modport sink (input valid, input axis_status, output ready);
endinterface

### rtl/core/three_axis_window_average_check_top.sv
// Three-axis window average check, top level.
// Depends on twac_pkg, twac_ifs, twac_limit_regs and twac_axis.
//
// Takes one x/y/z accelerometer sample (signed Q8.8) per transfer and
// returns one axis_status per sample: 0 when the mean of the last WINDOW
// samples of every axis lies strictly between that axis's low and high
// limits, else 1, 2 or 3 for the first failing axis in x, y, z order.
// Until WINDOW samples have arrived the missing entries count as zero
// and the mean is still taken over WINDOW entries. A sample transfer can
// be taken every cycle while the output is not stalled; each sample passes
// the stage-1 register, where the old ring entry is read from each axis
// memory, and its status is then held in the status register. The rings
// clear through per-entry valid bits, so the block is ready right after
// reset with no clearing sweep. Limits are written
// through cfg_we/cfg_idx/cfg_wdata (0 x low, 1 x high, 2 y low, 3 y high,
// 4 z low, 5 z high; other indexes are dropped) and are meant to change
// only while the block is idle.
module three_axis_window_average_check_top #(
	parameter int WINDOW = twac_pkg::WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	twac_sample_if.sink                     samples,
	twac_status_if.source                   status,
	input  logic                            cfg_we,
	input  twac_pkg::cfg_idx_t              cfg_idx,
	input  logic [twac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import twac_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	logic                    in_xfer;
	logic                    s1_valid_s1;
	logic                    s1_adv;
	logic [SLOT_W-1:0]       slot_q;
	ring_ctl_t               ring_ctl;
	logic [NUM_AXES-1:0]     fail;
	status_t                 status_nxt;
	status_t                 status_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] lo_lim [NUM_AXES];
	logic signed [SUM_W-1:0] hi_lim [NUM_AXES];
	sample_t                 axis_sample [NUM_AXES];

	// Stage 1 moves on whenever the status register is empty or being drained,
	// so a new sample can come in while a finished status still waits.
	assign s1_adv        = s1_valid_s1 && (!out_valid_q || status.ready);
	assign samples.ready = !s1_valid_s1 || s1_adv;
	assign in_xfer       = samples.valid && samples.ready;

	assign ring_ctl.load   = in_xfer;
	assign ring_ctl.commit = s1_adv;

	assign axis_sample[AXIS_X] = samples.sample_x;
	assign axis_sample[AXIS_Y] = samples.sample_y;
	assign axis_sample[AXIS_Z] = samples.sample_z;

	// Advance the ring write slot once per accepted sample, wrap at WINDOW.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (in_xfer) begin
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
			if (in_xfer) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	twac_limit_regs #(
		.WINDOW (WINDOW)
	) u_limits (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.lo_lim    (lo_lim),
		.hi_lim    (hi_lim)
	);

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		twac_axis #(
			.WINDOW (WINDOW)
		) u_axis (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ring_ctl),
			.slot         (slot_q),
			.sample       (axis_sample[a]),
			.lo_lim       (lo_lim[a]),
			.hi_lim       (hi_lim[a]),
			.out_of_range (fail[a])
		);
	end

	// Report the first failing axis in x, y, z order.
	always_comb begin
		if (fail[AXIS_X]) begin
			status_nxt = STAT_X_OUT;
		end else if (fail[AXIS_Y]) begin
			status_nxt = STAT_Y_OUT;
		end else if (fail[AXIS_Z]) begin
			status_nxt = STAT_Z_OUT;
		end else begin
			status_nxt = STAT_OK;
		end
	end

	// Hold the status until the sink takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q <= status_nxt;
		end
	end

	assign status.valid       = out_valid_q;
	assign status.axis_status = status_q;

endmodule

### rtl/core/twac_limit_regs.sv
// Limit register file: holds each limit pre-scaled by the window length.
// Depends on twac_pkg.
module twac_limit_regs #(
	parameter int WINDOW = twac_pkg::WINDOW_DEF,
	localparam int SUM_W = twac_pkg::SAMPLE_W + $clog2(WINDOW)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  twac_pkg::cfg_idx_t             cfg_idx,
	input  logic [twac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic signed [SUM_W-1:0]        lo_lim [twac_pkg::NUM_AXES],
	output logic signed [SUM_W-1:0]        hi_lim [twac_pkg::NUM_AXES]
);
	import twac_pkg::*;

	localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

	logic signed [SUM_W-1:0] lo_q [NUM_AXES];
	logic signed [SUM_W-1:0] hi_q [NUM_AXES];
	logic signed [SUM_W-1:0] wdata_ext;
	logic signed [SUM_W-1:0] wdata_scaled;

	// limit * WINDOW always fits in SUM_W bits
	assign wdata_ext    = SUM_W'(signed'(cfg_wdata));
	assign wdata_scaled = wdata_ext * WIN_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q[AXIS_X] <= SUM_W'(X_LOW_RST * WINDOW);
			hi_q[AXIS_X] <= SUM_W'(X_HIGH_RST * WINDOW);
			lo_q[AXIS_Y] <= SUM_W'(Y_LOW_RST * WINDOW);
			hi_q[AXIS_Y] <= SUM_W'(Y_HIGH_RST * WINDOW);
			lo_q[AXIS_Z] <= SUM_W'(Z_LOW_RST * WINDOW);
			hi_q[AXIS_Z] <= SUM_W'(Z_HIGH_RST * WINDOW);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_X_LOW:  lo_q[AXIS_X] <= wdata_scaled;
				REG_X_HIGH: hi_q[AXIS_X] <= wdata_scaled;
				REG_Y_LOW:  lo_q[AXIS_Y] <= wdata_scaled;
				REG_Y_HIGH: hi_q[AXIS_Y] <= wdata_scaled;
				REG_Z_LOW:  lo_q[AXIS_Z] <= wdata_scaled;
				REG_Z_HIGH: hi_q[AXIS_Z] <= wdata_scaled;
				default: ;
			endcase
		end
	end

	assign lo_lim = lo_q;
	assign hi_lim = hi_q;

endmodule

### rtl/core/twac_axis.sv
// One axis: sample ring memory with per-entry valid bits, running sum
// and the exclusive window test. Depends on twac_pkg.
module twac_axis #(
	parameter int WINDOW  = twac_pkg::WINDOW_DEF,
	localparam int SUM_W  = twac_pkg::SAMPLE_W + $clog2(WINDOW),
	localparam int SLOT_W = $clog2(WINDOW)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  twac_pkg::ring_ctl_t     ctl,
	input  logic [SLOT_W-1:0]       slot,
	input  twac_pkg::sample_t       sample,
	input  logic signed [SUM_W-1:0] lo_lim,
	input  logic signed [SUM_W-1:0] hi_lim,
	output logic                    out_of_range
);
	import twac_pkg::*;

	sample_t                 mem [WINDOW];
	logic [WINDOW-1:0]       vld_q;
	sample_t                 sample_s1;
	sample_t                 old_raw_s1;
	logic                    old_vld_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] sum_nxt;

	// Load and commit never touch the same slot (WINDOW >= 2).
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			old_raw_s1 <= mem[slot];
			old_vld_s1 <= vld_q[slot];
			sample_s1  <= sample;
			slot_s1    <= slot;
		end
		if (ctl.commit) begin
			mem[slot_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			sum_q <= '0;
		end else if (ctl.commit) begin
			vld_q[slot_s1] <= 1'b1;
			sum_q          <= sum_nxt;
		end
	end

	// An entry never written reads as zero.
	assign new_ext = SUM_W'(sample_s1);
	assign old_ext = old_vld_s1 ? SUM_W'(old_raw_s1) : '0;
	assign sum_nxt = sum_q + new_ext - old_ext;

	assign out_of_range = !((sum_nxt > lo_lim) && (sum_nxt < hi_lim));

endmodule

### rtl/core/twac_check.sv
// Port-level checker for the three-axis window average check, and its bind.
// Depends on twac_pkg and three_axis_window_average_check_top_assert.svh.
`include "three_axis_window_average_check_top_assert.svh"

module twac_check (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input twac_pkg::status_t axis_status
);
	// A stalled status stays offered.
	`TWAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "status dropped while stalled")
	// A stalled status keeps its value.
	`TWAC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(axis_status), "status changed while stalled")
	// With the output register empty the input side must take samples.
	`TWAC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty output")
	// Every accepted sample is followed by an offered status.
	`TWAC_ASSERT_NEXT(a_status_follows, in_valid && in_ready, ##1 out_valid, "no status after sample")

endmodule

bind three_axis_window_average_check_top twac_check u_twac_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (status.valid),
	.out_ready   (status.ready),
	.axis_status (status.axis_status)
);

### sim/three_axis_window_average_check_top_tb.sv
// Self-checking testbench for three_axis_window_average_check_top.
// Depends on twac_pkg, twac_ifs and the RTL of the block; needs no files or arguments.
// A directed table runs first, then random sample streams under changing limit settings.
module three_axis_window_average_check_top_tb;
	import twac_pkg::*;

	localparam int WINDOW         = WINDOW_DEF;
	localparam int NUM_PHASES     = 10;
	localparam int PHASE_SAMPLES  = 115;
	localparam int HOLD_CYCLES    = 60;
	localparam int TAIL_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int IDLE_PERCENT   = 6;

	// Indexes past the register list; writes there must be dropped.
	localparam cfg_idx_t REG_SPARE_LO = REG_Z_HIGH + 3'd1;
	localparam cfg_idx_t REG_SPARE_HI = REG_Z_HIGH + 3'd2;

	localparam cfg_idx_t LOW_REG [NUM_AXES] = '{REG_X_LOW, REG_Y_LOW, REG_Z_LOW};
	localparam cfg_idx_t HIGH_REG[NUM_AXES] = '{REG_X_HIGH, REG_Y_HIGH, REG_Z_HIGH};
	localparam int       RST_LOW [NUM_AXES] = '{X_LOW_RST, Y_LOW_RST, Z_LOW_RST};
	localparam int       RST_HIGH[NUM_AXES] = '{X_HIGH_RST, Y_HIGH_RST, Z_HIGH_RST};

	typedef enum logic {ROW_SAMPLE, ROW_LIMIT} row_kind_e;
	typedef enum int {LIM_RESET, LIM_WIDE, LIM_EQUAL, LIM_NARROW, LIM_ANY} lim_mode_e;

	typedef struct packed {
		row_kind_e         kind;
		sample_t           x;
		sample_t           y;
		sample_t           z;
		cfg_idx_t          idx;
		logic [CFG_DATA_W-1:0] data;
		logic              known;
		status_t           status;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	twac_sample_if sample_ch();
	twac_status_if status_ch();

	three_axis_window_average_check_top #(
		.WINDOW(WINDOW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.status    (status_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Window model: ring contents, exact running sums, write slot and limits.
	sample_t               axis_ring[NUM_AXES][WINDOW];
	longint                axis_sum[NUM_AXES];
	int                    ring_slot;
	logic signed [15:0]    low_limit[NUM_AXES];
	logic signed [15:0]    high_limit[NUM_AXES];

	status_t pending_status[$];

	int  mismatches     = 0;
	int  samples_sent   = 0;
	int  statuses_seen  = 0;
	int  limit_settings = 0;
	int  status_hits[4] = '{0, 0, 0, 0};
	bit  quiet          = 1'b0;    // no idling on either side while set
	bit  hold_request   = 1'b0;    // ask the receiver for a long hold-off
	int  stall_cycles   = 0;

	task automatic reset_window_model();
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int i = 0; i < WINDOW; i++)
				axis_ring[a][i] = '0;
			axis_sum[a]   = 0;
			low_limit[a]  = CFG_DATA_W'(RST_LOW[a]);
			high_limit[a] = CFG_DATA_W'(RST_HIGH[a]);
		end
		ring_slot = 0;
	endtask

	function automatic bit mean_in_range(int a);
		return axis_sum[a] > longint'(low_limit[a]) * WINDOW
			&& axis_sum[a] < longint'(high_limit[a]) * WINDOW;
	endfunction

	// Retire one sample into the rings and return the status it must produce.
	function automatic status_t advance_window(sample_t x, sample_t y, sample_t z);
		sample_t fresh[NUM_AXES];
		fresh[AXIS_X] = x;
		fresh[AXIS_Y] = y;
		fresh[AXIS_Z] = z;
		for (int a = 0; a < NUM_AXES; a++) begin
			axis_sum[a] += longint'(fresh[a]) - longint'(axis_ring[a][ring_slot]);
			axis_ring[a][ring_slot] = fresh[a];
		end
		ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
		if (!mean_in_range(AXIS_X))
			return STAT_X_OUT;
		if (!mean_in_range(AXIS_Y))
			return STAT_Y_OUT;
		if (!mean_in_range(AXIS_Z))
			return STAT_Z_OUT;
		return STAT_OK;
	endfunction

	function automatic row_t smp(int x, int y, int z, logic known, status_t st);
		row_t r;
		r = '0;
		r.kind   = ROW_SAMPLE;
		r.x      = sample_t'(x);
		r.y      = sample_t'(y);
		r.z      = sample_t'(z);
		r.known  = known;
		r.status = st;
		return r;
	endfunction

	function automatic row_t lim(cfg_idx_t idx, int data);
		row_t r;
		r = '0;
		r.kind = ROW_LIMIT;
		r.idx  = idx;
		r.data = data[CFG_DATA_W-1:0];
		return r;
	endfunction

	// Offer one sample, hold it until the transfer, then maybe idle.
	// A typed-in status, where given, replaces the model's for the check.
	task automatic push_sample(sample_t x, sample_t y, sample_t z, logic known,
		status_t typed);
		status_t predicted;
		sample_ch.valid    <= 1'b1;
		sample_ch.sample_x <= x;
		sample_ch.sample_y <= y;
		sample_ch.sample_z <= z;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predicted = advance_window(x, y, z);
		pending_status.push_back(known ? typed : predicted);
		samples_sent++;
		if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every outstanding status has come back.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	// Raise the write enable and present one register write; the caller lowers it after a burst.
	task automatic write_limit(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_X_LOW:  low_limit[AXIS_X]  = data;
			REG_X_HIGH: high_limit[AXIS_X] = data;
			REG_Y_LOW:  low_limit[AXIS_Y]  = data;
			REG_Y_HIGH: high_limit[AXIS_Y] = data;
			REG_Z_LOW:  low_limit[AXIS_Z]  = data;
			REG_Z_HIGH: high_limit[AXIS_Z] = data;
			default: ;
		endcase
	endtask

	task automatic choose_limits(lim_mode_e mode, int a, output int lo, output int hi);
		int center;
		int half;
		case (mode)
			LIM_RESET: begin
				lo = RST_LOW[a];
				hi = RST_HIGH[a];
			end
			LIM_WIDE: begin
				lo = -32768;
				hi = 32767;
			end
			LIM_EQUAL: begin
				lo = int'(sample_t'($urandom));
				hi = lo;
			end
			LIM_NARROW: begin
				center = int'($urandom_range(0, 16000)) - 8000;
				half   = int'($urandom_range(1, 2000));
				lo = center - half;
				hi = center + half;
			end
			default: begin
				lo = int'(sample_t'($urandom));
				hi = int'(sample_t'($urandom));
			end
		endcase
	endtask

	// Aim most samples at a limit or the middle of the band so the window
	// mean keeps crossing the bounds; mix in full-scale noise and extremes.
	function automatic sample_t pick_sample(int lo, int hi);
		int r;
		int target;
		int spread;
		int v;
		r = $urandom_range(0, 99);
		if (r < 8)
			return sample_t'($urandom);
		if (r < 14)
			return $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
		case ($urandom_range(0, 2))
			0: target = lo;
			1: target = hi;
			default: target = (lo + hi) / 2;
		endcase
		spread = ((hi > lo) ? hi - lo : lo - hi) / 4 + 16;
		if (spread > 32767)
			spread = 32767;
		v = target + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return sample_t'(v);
	endfunction

	// Receiver: random back-pressure, plus a long hold-off on request so the
	// pipeline fills and the block stalls its sample input.
	initial begin
		status_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_cycles > 0) begin
				status_ch.ready <= 1'b0;
				stall_cycles--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_cycles = HOLD_CYCLES - 1;
				status_ch.ready <= 1'b0;
			end else begin
				status_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Status checker: every transfer must match the oldest expectation.
	always @(posedge clk) begin
		status_t want;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			statuses_seen++;
			status_hits[status_ch.axis_status]++;
			if (pending_status.size() == 0) begin
				$error("axis_status: no status expected, got %0d", status_ch.axis_status);
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				if (status_ch.axis_status !== want) begin
					$error("axis_status: expected %0d, got %0d", want,
						status_ch.axis_status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either channel for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready)
				|| (status_ch.valid && status_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d statuses outstanding",
					WATCHDOG_LIMIT, pending_status.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		row_t      directed_rows[$];
		bit        writing;
		lim_mode_e mode;
		int        lo[NUM_AXES];
		int        hi[NUM_AXES];
		int        pick;

		// Hold every input at a known value from time zero.
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_idx            <= REG_X_LOW;
		cfg_wdata          <= '0;
		sample_ch.valid    <= 1'b0;
		sample_ch.sample_x <= '0;
		sample_ch.sample_y <= '0;
		sample_ch.sample_z <= '0;
		reset_window_model();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Rows with a typed status can be read off directly:
		// after reset the sums start at zero against the reset limits.
		directed_rows = '{
			smp(0, 0, 0, 1'b1, STAT_OK),
			smp(32767, 0, 0, 1'b1, STAT_OK),
			smp(32767, 0, 0, 1'b1, STAT_OK),
			smp(32767, 0, 0, 1'b1, STAT_X_OUT),          // x sum past 15.0 * WINDOW
			smp(-32768, 32767, 0, 1'b1, STAT_Y_OUT),
			smp(-32768, -32768, -32768, 1'b1, STAT_Z_OUT),
			smp(-32768, 0, 32767, 1'b1, STAT_OK),         // sums now -3, -1, -1
			// Widest x and y bands, z band (-1, 0).
			lim(REG_X_LOW, -32768),
			lim(REG_X_HIGH, 32767),
			lim(REG_Y_LOW, -32768),
			lim(REG_Y_HIGH, 32767),
			lim(REG_Z_LOW, -1),
			lim(REG_Z_HIGH, 0),
			smp(0, 0, -19, 1'b1, STAT_Z_OUT),             // z mean sits on the low bound
			smp(0, 0, 1, 1'b1, STAT_OK),
			// Low above high: y can never pass.
			lim(REG_Y_LOW, 100),
			lim(REG_Y_HIGH, -100),
			smp(0, 0, 0, 1'b1, STAT_Y_OUT),
			// Writes past the register list change nothing.
			lim(REG_SPARE_LO, -32768),
			lim(REG_SPARE_HI, 32767),
			smp(0, 0, 0, 1'b1, STAT_Y_OUT),
			smp(21845, -21846, 3855, 1'b0, STAT_OK),
			smp(-21846, 21845, -3856, 1'b0, STAT_OK)
		};

		writing = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LIMIT) begin
				if (!writing) begin
					drain();
					writing = 1'b1;
					limit_settings++;
				end
				write_limit(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				push_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
					directed_rows[i].known, directed_rows[i].status);
			end
		end

		// Random part: new limits each phase, written only once the block drains.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			for (int a = 0; a < NUM_AXES; a++) begin
				pick = $urandom_range(0, 9);
				if (p == 0)
					mode = LIM_WIDE;
				else if (p == 1 && a == AXIS_Z)
					mode = LIM_EQUAL;
				else if (pick < 4)
					mode = LIM_NARROW;
				else if (pick < 6)
					mode = LIM_RESET;
				else if (pick == 6)
					mode = LIM_WIDE;
				else if (pick == 7)
					mode = LIM_EQUAL;
				else
					mode = LIM_ANY;
				choose_limits(mode, a, lo[a], hi[a]);
				write_limit(LOW_REG[a], lo[a][CFG_DATA_W-1:0]);
				write_limit(HIGH_REG[a], hi[a][CFG_DATA_W-1:0]);
			end
			if ($urandom_range(0, 3) == 0)
				write_limit($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					CFG_DATA_W'($urandom));
			cfg_we <= 1'b0;
			limit_settings++;

			// One phase runs with no idling at all; two start with a long hold-off.
			quiet = (p == 4);
			if (p == 2 || p == 7)
				hold_request = 1'b1;

			for (int n = 0; n < PHASE_SAMPLES; n++)
				push_sample(pick_sample(lo[AXIS_X], hi[AXIS_X]),
					pick_sample(lo[AXIS_Y], hi[AXIS_Y]),
					pick_sample(lo[AXIS_Z], hi[AXIS_Z]), 1'b0, STAT_OK);
		end

		drain();
		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run: %0d samples, %0d statuses checked over %0d limit settings",
			samples_sent, statuses_seen, limit_settings);
		$display("Status mix: in range %0d, x out %0d, y out %0d, z out %0d",
			status_hits[STAT_OK], status_hits[STAT_X_OUT], status_hits[STAT_Y_OUT],
			status_hits[STAT_Z_OUT]);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
